// ===== rtl/mmf_pkg.sv =====
package mmf_pkg;

	localparam int MAX_WINDOW  = 15;
	localparam int SAMPLE_BITS = 16;
	localparam int JIT_BITS    = 16;
	localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
	localparam int AGE_BITS    = LEN_BITS;

	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(3);
	localparam logic [LEN_BITS-1:0] LEN_NONE  = LEN_BITS'(0);

	// one window entry: sample plus its age in beats
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic [JIT_BITS-1:0]           jitter;
		logic [AGE_BITS-1:0]           age;
	} entry_t;

	// handed left to right: neighbor content and whether it sorts before the new beat
	typedef struct packed {
		logic   valid;
		logic   le;
		entry_t ent;
	} link_t;

	// merged list position, handed right to left for the eviction shift
	typedef struct packed {
		logic   valid;
		entry_t ent;
	} merge_t;

	// per beat controls broadcast to every cell
	typedef struct packed {
		logic                step;
		logic                clear;
		logic [LEN_BITS-1:0] len;
		entry_t              fresh_ent;
	} cell_ctl_t;

endpackage

// ===== rtl/mmf_intf.sv =====
interface mmf_sample_if;
	import mmf_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic [JIT_BITS-1:0]           sample_jitter;
	modport source (output valid, output sample_value, output sample_jitter, input ready);
	modport sink (input valid, input sample_value, input sample_jitter, output ready);
endinterface

interface mmf_median_if;
	import mmf_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] median_value;
	logic [JIT_BITS-1:0]           median_jitter;
	logic                          fresh;
	modport source (output valid, output median_value, output median_jitter, output fresh,
		input ready);
	modport sink (input valid, input median_value, input median_jitter, input fresh,
		output ready);
endinterface

interface mmf_cfg_if;
	import mmf_pkg::*;
	logic                valid;
	logic                ready;
	logic [LEN_BITS-1:0] window_length;
	modport source (output valid, output window_length, input ready);
	modport sink (input valid, input window_length, output ready);
endinterface

// ===== rtl/mmf_cell.sv =====
module mmf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mmf_pkg::cell_ctl_t ctl,
	input  mmf_pkg::link_t     left,
	output mmf_pkg::link_t     right,
	input  mmf_pkg::merge_t    merge_next,
	output mmf_pkg::merge_t    merge_here,
	input  logic               evict_in,
	output logic               evict_out
);
	import mmf_pkg::*;

	logic   valid_q;
	entry_t ent_q;
	logic   le;
	merge_t merged;
	merge_t nxt;
	logic   oldest;

	// sorts before the new beat: equal values keep the older one first
	assign le = valid_q && (ent_q.value <= ctl.fresh_ent.value);

	assign right = '{valid: valid_q, le: le, ent: ent_q};

	// content of this position once the new beat is inserted
	always_comb begin
		merged = '0;
		if (le) begin
			merged.valid   = 1'b1;
			merged.ent     = ent_q;
			merged.ent.age = ent_q.age + AGE_BITS'(1);
		end else if (left.le) begin
			merged.valid = 1'b1;
			merged.ent   = ctl.fresh_ent;
		end else begin
			merged.valid   = left.valid;
			merged.ent     = left.ent;
			merged.ent.age = left.ent.age + AGE_BITS'(1);
		end
	end

	assign merge_here = merged;

	// the oldest entry drops out, everything after it moves one place left
	assign oldest    = merged.valid && (merged.ent.age == ctl.len - LEN_BITS'(1));
	assign evict_out = evict_in | oldest;
	assign nxt       = evict_out ? merge_next : merged;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.step) begin
			valid_q <= nxt.valid;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			ent_q <= nxt.ent;
		end
	end

endmodule

// ===== rtl/moving_median_filter_unit.sv =====
// channel     | dir | beat contents
// sample_in   | in  | sample_value, sample_jitter
// median_out  | out | median_value, median_jitter, fresh
// cfg         | in  | window_length (0 is ignored, any other value empties the window)
//
// a sorted row of cells inserts the new sample, picks the median and evicts the
// oldest entry in the same cycle, one beat per clock while the output is not stalled.
// the result sits in an output register; a new sample is taken while it is
// taken or the register is empty, so a stalled output stalls the input.
// reset empties the window, sets the length to 3 and the last result to zero.
module moving_median_filter_unit (
	input logic           clk,
	input logic           arst_n,
	mmf_sample_if.sink    sample_in,
	mmf_median_if.source  median_out,
	mmf_cfg_if.sink       cfg
);
	import mmf_pkg::*;

	logic [LEN_BITS-1:0]           len_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] last_val_q;
	logic [JIT_BITS-1:0]           last_jit_q;
	logic                          fresh_q;

	logic      step;
	logic      clear;
	cell_ctl_t ctl;
	link_t     lk [0:MAX_WINDOW];
	merge_t    mg [0:MAX_WINDOW];
	logic      ev [0:MAX_WINDOW];
	merge_t    med;

	// handshakes
	assign sample_in.ready = !out_valid_q || median_out.ready;
	assign cfg.ready       = 1'b1;
	assign step            = sample_in.valid && sample_in.ready;
	assign clear           = cfg.valid && (cfg.window_length != LEN_NONE);

	assign ctl = '{step: step, clear: clear, len: len_q,
		fresh_ent: '{value: sample_in.sample_value, jitter: sample_in.sample_jitter,
		age: '0}};

	// chain ends
	assign lk[0]          = '{valid: 1'b1, le: 1'b1, ent: '0};
	assign ev[0]          = 1'b0;
	assign mg[MAX_WINDOW] = '0;

	// sorted row of cells
	for (genvar p = 0; p < MAX_WINDOW; p++) begin : g_cell
		mmf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left       (lk[p]),
			.right      (lk[p+1]),
			.merge_next (mg[p+1]),
			.merge_here (mg[p]),
			.evict_in   (ev[p]),
			.evict_out  (ev[p+1])
		);
	end

	// median sits at merged position len/2
	assign med = mg[len_q >> 1];

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (clear) begin
			len_q <= cfg.window_length;
		end
	end

	// output register, holds the last median between fresh results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fresh_q     <= 1'b0;
			last_val_q  <= '0;
			last_jit_q  <= '0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
				fresh_q     <= ev[MAX_WINDOW];
				if (ev[MAX_WINDOW]) begin
					last_val_q <= med.ent.value;
					last_jit_q <= med.ent.jitter;
				end
			end else if (median_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign median_out.valid         = out_valid_q;
	assign median_out.median_value  = last_val_q;
	assign median_out.median_jitter = last_jit_q;
	assign median_out.fresh         = fresh_q;

endmodule
